FILE: src/sequential_key_insert_path_selector_defines.svh
// Assertion macros for the sequential key insert path selector checker.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef SEQUENTIAL_KEY_INSERT_PATH_SELECTOR_DEFINES_SVH
`define SEQUENTIAL_KEY_INSERT_PATH_SELECTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SKIQ_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("skiq: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SKIQ_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("skiq: next-cycle check failed");

`endif

FILE: src/skiq_pkg.sv
// Package for the sequential key insert path selector: types, codes,
// register map constants and small helper functions. No dependencies.
package skiq_pkg;

	localparam int unsigned KEY_W     = 32;
	localparam int unsigned PAT_W     = 16;
	localparam int unsigned CNT_W     = 32;
	localparam int unsigned PADDR_W   = 3;
	localparam int unsigned IN_DATA_W = 32;
	localparam int unsigned IN_USER_W = 2;
	localparam int unsigned OUT_DATA_W = 152;
	localparam int unsigned OUT_USER_W = 3;

	localparam logic [PAT_W-1:0] RELOAD_DEFAULT = 16'd300;
	localparam logic             START_DEFAULT  = 1'b1;
	localparam logic [7:0]       BYTE_ALL_ONES  = 8'hFF;
	localparam logic [CNT_W-1:0] CNT_FULL       = 32'hFFFF_FFFF;

	// register index, taken from paddr[2]
	localparam logic REG_RELOAD = 1'b0;
	localparam logic REG_START  = 1'b1;

	typedef enum logic [2:0] {
		PATH_BYPASS   = 3'd0,
		PATH_FIRST    = 3'd1,
		PATH_FAST     = 3'd2,
		PATH_PRESERVE = 3'd3,
		PATH_BRIDGE   = 3'd4,
		PATH_RESET    = 3'd5
	} path_t;

	typedef struct packed {
		logic [PAT_W-1:0] reload;
		logic             start_dir;
	} cfg_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic             four;
		logic             ok;
	} item_t;

	typedef struct packed {
		path_t            path;
		logic             dir;
		logic [PAT_W-1:0] patience;
		logic [CNT_W-1:0] fast_total;
		logic [CNT_W-1:0] regular_total;
		logic [CNT_W-1:0] bridge_total;
		logic [CNT_W-1:0] reset_total;
	} result_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_FULL) ? v : v + CNT_W'(1);
	endfunction

endpackage

FILE: src/skiq_cfg.sv
// APB register block: reload value and start direction.
// Depends on skiq_pkg.
module skiq_cfg import skiq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output cfg_t               cfg
);

	logic [PAT_W-1:0] reload_q;
	logic             start_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q <= RELOAD_DEFAULT;
			start_q  <= START_DEFAULT;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_RELOAD: reload_q <= pwdata[PAT_W-1:0];
				REG_START:  start_q  <= pwdata[0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_RELOAD: prdata = {{(32-PAT_W){1'b0}}, reload_q};
			REG_START:  prdata = {31'b0, start_q};
		endcase
	end

	assign cfg.reload    = reload_q;
	assign cfg.start_dir = start_q;

endmodule

FILE: src/skiq_core.sv
// Path decision and block state: anchor, direction, patience, statistics.
// The result is the state after the request. Depends on skiq_pkg.
module skiq_core import skiq_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t res
);

	logic [KEY_W-1:0] anchor_q;
	logic             valid_q;
	logic             dir_q;
	logic [PAT_W-1:0] pat_q;
	logic [CNT_W-1:0] fast_q, regular_q, bridge_q, expiry_q;

	logic [KEY_W-1:0] anchor_d;
	logic             valid_d, dir_d;
	logic [PAT_W-1:0] pat_d;
	logic [CNT_W-1:0] fast_d, regular_d, bridge_d, expiry_d;
	path_t            path;

	logic [2:0]       diff;
	logic [7:0]       kb, ab;
	logic             key_larger, with_dir, bridge;
	logic [KEY_W-1:0] hi, lo;

	assign diff[0] = item.key[31:24] != anchor_q[31:24];
	assign diff[1] = item.key[23:16] != anchor_q[23:16];
	assign diff[2] = item.key[15:8]  != anchor_q[15:8];

	// byte at the first differing position
	always_comb begin
		if (diff[0]) begin
			kb = item.key[31:24];
			ab = anchor_q[31:24];
		end else if (diff[1]) begin
			kb = item.key[23:16];
			ab = anchor_q[23:16];
		end else begin
			kb = item.key[15:8];
			ab = anchor_q[15:8];
		end
	end

	assign key_larger = kb > ab;
	assign with_dir   = dir_q ? key_larger : !key_larger;
	assign hi         = key_larger ? item.key : anchor_q;
	assign lo         = key_larger ? anchor_q : item.key;

	// bridge: hi byte one above lo byte, then hi all zero and lo all ones
	always_comb begin
		if (diff[0]) begin
			bridge = ({1'b0, hi[31:24]} == {1'b0, lo[31:24]} + 9'd1)
				&& (hi[23:8] == 16'd0) && (lo[23:8] == {BYTE_ALL_ONES, BYTE_ALL_ONES});
		end else if (diff[1]) begin
			bridge = ({1'b0, hi[23:16]} == {1'b0, lo[23:16]} + 9'd1)
				&& (hi[15:8] == 8'd0) && (lo[15:8] == BYTE_ALL_ONES);
		end else begin
			bridge = {1'b0, hi[15:8]} == {1'b0, lo[15:8]} + 9'd1;
		end
	end

	always_comb begin
		anchor_d  = anchor_q;
		valid_d   = valid_q;
		dir_d     = dir_q;
		pat_d     = pat_q;
		fast_d    = fast_q;
		regular_d = regular_q;
		bridge_d  = bridge_q;
		expiry_d  = expiry_q;
		path      = PATH_BYPASS;
		if (!item.four) begin
			path = PATH_BYPASS;
		end else if (!valid_q) begin
			path = PATH_FIRST;
			if (item.ok) begin
				anchor_d  = item.key;
				valid_d   = 1'b1;
				regular_d = sat_inc(regular_q);
			end
		end else if (diff == 3'b000) begin
			path = PATH_FAST;
			if (dir_q && (item.key[7:0] < anchor_q[7:0])) begin
				dir_d = 1'b0;
			end else if (!dir_q && (item.key[7:0] > anchor_q[7:0])) begin
				dir_d = 1'b1;
			end
			pat_d    = cfg.reload;
			fast_d   = sat_inc(fast_q);
			anchor_d = item.key;
		end else begin
			regular_d = sat_inc(regular_q);
			if (with_dir && bridge) begin
				path     = PATH_BRIDGE;
				pat_d    = cfg.reload;
				bridge_d = sat_inc(bridge_q);
				anchor_d = item.key;
			end else if (with_dir && (pat_q == '0)) begin
				path     = PATH_RESET;
				pat_d    = cfg.reload;
				expiry_d = sat_inc(expiry_q);
				dir_d    = 1'b1;
				anchor_d = item.key;
			end else begin
				path = PATH_PRESERVE;
				// hold at zero
				if (pat_q != '0) begin
					pat_d = pat_q - PAT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anchor_q  <= '0;
			valid_q   <= 1'b0;
			dir_q     <= START_DEFAULT;
			pat_q     <= RELOAD_DEFAULT;
			fast_q    <= '0;
			regular_q <= '0;
			bridge_q  <= '0;
			expiry_q  <= '0;
		end else if (en) begin
			anchor_q  <= anchor_d;
			valid_q   <= valid_d;
			dir_q     <= dir_d;
			pat_q     <= pat_d;
			fast_q    <= fast_d;
			regular_q <= regular_d;
			bridge_q  <= bridge_d;
			expiry_q  <= expiry_d;
		end
	end

	assign res.path          = path;
	assign res.dir           = dir_d;
	assign res.patience      = pat_d;
	assign res.fast_total    = fast_d;
	assign res.regular_total = regular_d;
	assign res.bridge_total  = bridge_d;
	assign res.reset_total   = expiry_d;

endmodule

FILE: src/sequential_key_insert_path_selector.sv
// Sequential key insert path selector, top level: stream ports, input and
// result registers. Depends on skiq_pkg, skiq_cfg and skiq_core.
//
// Usage:
//   Input stream s_*: one insert request per transaction, key in s_tdata,
//   four_byte_key and store_ok flags in s_tuser.
//   Output stream m_*: one result per request, path code in m_tuser,
//   direction, patience and the four statistics counters in m_tdata.
//   APB port: register 0 (address 0) reload value, register 1 (address 4)
//   start direction; pready is always high.
//   Each request passes the input register, then the result register, on its
//   way to m_tvalid. Throughput: one request per cycle while m_tready is high;
//   the decision and state update is a single pass of logic between the two
//   registers. When m_tready is low the result register holds and one more
//   request waits in the input register; s_tready then drops until m_tready rises.
//   Reset clears the anchor and counters, sets the direction forward and the
//   patience counter to 300, and restores both registers to their defaults.
module sequential_key_insert_path_selector import skiq_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // [31:0] key_value
	input  logic [IN_USER_W-1:0]  s_tuser,  // [0] four_byte_key, [1] store_ok
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [0] direction_now, [16:1] patience_now, [48:17] fast_total,
	// [80:49] regular_total, [112:81] bridge_total, [144:113] reset_total,
	// [151:145] zero
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [OUT_USER_W-1:0] m_tuser,  // [2:0] path_taken
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    v_s1;
	result_t res;
	result_t res_s2;
	logic    v_s2;
	logic    adv;

	skiq_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	// advance the held request into the result register
	assign adv      = v_s1 && (!v_s2 || m_tready);
	assign s_tready = !v_s1 || adv;

	skiq_core u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (adv),
		.item  (item_s1),
		.cfg   (cfg),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				v_s1 <= s_tvalid;
			end
			if (adv) begin
				v_s2 <= 1'b1;
			end else if (m_tready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.key  <= s_tdata;
			item_s1.four <= s_tuser[0];
			item_s1.ok   <= s_tuser[1];
		end
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = v_s2;
	assign m_tuser  = res_s2.path;
	assign m_tdata  = {7'd0, res_s2.reset_total, res_s2.bridge_total,
		res_s2.regular_total, res_s2.fast_total, res_s2.patience, res_s2.dir};

endmodule

FILE: src/skiq_checker.sv
// Port-level checker for the sequential key insert path selector, and the
// bind that attaches it. Depends on skiq_pkg and the defines header.
`include "sequential_key_insert_path_selector_defines.svh"

module skiq_checker import skiq_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic [OUT_USER_W-1:0] m_tuser
);

	logic [OUT_DATA_W-1:0] last_q;
	logic                  seen_q;
	logic                  out_acc;

	assign out_acc = m_tvalid && m_tready;

	// hold the last delivered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (out_acc) begin
			seen_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_acc) begin
			last_q <= m_tdata;
		end
	end

	`SKIQ_ASSERT_NXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	`SKIQ_ASSERT_IMP(a_bypass_no_change, m_tvalid && seen_q && (m_tuser == PATH_BYPASS), m_tdata == last_q)
	`SKIQ_ASSERT_IMP(a_reset_forward, m_tvalid && (m_tuser == PATH_RESET), m_tdata[0] == 1'b1)
	`SKIQ_ASSERT_IMP(a_fast_counts, m_tvalid && seen_q && (m_tuser == PATH_FAST), m_tdata[48:17] == sat_inc(last_q[48:17]))

endmodule

bind sequential_key_insert_path_selector skiq_checker u_skiq_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

FILE: verif/skiq_path_checker.sv
// Path checker for the sequential key insert path selector: watches the request,
// result and register channels, predicts each result and compares it.
// Depends on skiq_pkg only.
`timescale 1ns / 1ps
module skiq_path_checker import skiq_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [IN_USER_W-1:0]  s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	input  logic [OUT_USER_W-1:0] m_tuser,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [31:0]           pwdata,
	input  logic                  pready,
	output int unsigned           errors,
	output int unsigned           pending
);

	typedef logic [31:0] field_row_t [7];

	string field_name [7] = '{"path_taken", "direction_now", "patience_now", "fast_total",
		"regular_total", "bridge_total", "reset_total"};

	// register copies
	logic [PAT_W-1:0] reload;
	logic             start_dir;

	// walk state
	logic [KEY_W-1:0] anchor;
	logic             anchor_set;
	logic             walk_fwd;
	logic [PAT_W-1:0] patience;
	logic [CNT_W-1:0] fast_cnt;
	logic [CNT_W-1:0] regular_cnt;
	logic [CNT_W-1:0] bridge_cnt;
	logic [CNT_W-1:0] expiry_cnt;

	result_t awaited_decisions [$];

	function automatic logic [7:0] byte_at(input logic [KEY_W-1:0] k, input int pos);
		return k[31 - 8 * pos -: 8];
	endfunction

	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	// hi is the side whose differing byte is larger
	function automatic logic crosses_boundary(input logic [KEY_W-1:0] hi,
			input logic [KEY_W-1:0] lo, input int d);
		logic hit;
		int k;
		hit = ({1'b0, byte_at(hi, d)} == {1'b0, byte_at(lo, d)} + 9'd1);
		for (k = d + 1; k < 3; k++)
			if (byte_at(hi, k) != 8'h00 || byte_at(lo, k) != BYTE_ALL_ONES)
				hit = 1'b0;
		return hit;
	endfunction

	function automatic result_t select_path(input logic [KEY_W-1:0] key, input logic four,
			input logic ok);
		result_t r;
		path_t path;
		int d;
		int k;
		logic larger;
		logic with_dir;
		logic bridge;
		d = 3;
		if (!four) begin
			path = PATH_BYPASS;
		end else if (!anchor_set) begin
			path = PATH_FIRST;
			if (ok) begin
				anchor = key;
				anchor_set = 1'b1;
				regular_cnt = bump(regular_cnt);
			end
		end else begin
			for (k = 0; k < 3 && d == 3; k++)
				if (byte_at(key, k) != byte_at(anchor, k))
					d = k;
			if (d == 3) begin
				// low byte against the walk flips it
				if (walk_fwd && key[7:0] < anchor[7:0])
					walk_fwd = 1'b0;
				else if (!walk_fwd && key[7:0] > anchor[7:0])
					walk_fwd = 1'b1;
				patience = reload;
				fast_cnt = bump(fast_cnt);
				anchor = key;
				path = PATH_FAST;
			end else begin
				larger = byte_at(key, d) > byte_at(anchor, d);
				with_dir = walk_fwd ? larger : !larger;
				bridge = with_dir && (larger ? crosses_boundary(key, anchor, d)
					: crosses_boundary(anchor, key, d));
				regular_cnt = bump(regular_cnt);
				if (bridge) begin
					patience = reload;
					bridge_cnt = bump(bridge_cnt);
					anchor = key;
					path = PATH_BRIDGE;
				end else if (with_dir && patience == '0) begin
					patience = reload;
					expiry_cnt = bump(expiry_cnt);
					walk_fwd = 1'b1;
					anchor = key;
					path = PATH_RESET;
				end else begin
					// hold at zero
					if (patience != '0)
						patience = patience - 1'b1;
					path = PATH_PRESERVE;
				end
			end
		end
		r.path = path;
		r.dir = walk_fwd;
		r.patience = patience;
		r.fast_total = fast_cnt;
		r.regular_total = regular_cnt;
		r.bridge_total = bridge_cnt;
		r.reset_total = expiry_cnt;
		return r;
	endfunction

	function automatic field_row_t flatten(input result_t r);
		field_row_t f;
		f[0] = 32'(r.path);
		f[1] = 32'(r.dir);
		f[2] = 32'(r.patience);
		f[3] = r.fast_total;
		f[4] = r.regular_total;
		f[5] = r.bridge_total;
		f[6] = r.reset_total;
		return f;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t got;
		field_row_t want_f;
		field_row_t got_f;
		int i;
		if (!arst_n) begin
			reload = RELOAD_DEFAULT;
			start_dir = START_DEFAULT;
			anchor = '0;
			anchor_set = 1'b0;
			walk_fwd = start_dir;
			patience = reload;
			fast_cnt = '0;
			regular_cnt = '0;
			bridge_cnt = '0;
			expiry_cnt = '0;
			awaited_decisions.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_RELOAD)
					reload = pwdata[PAT_W-1:0];
				else
					start_dir = pwdata[0];
			end
			if (m_tvalid && m_tready) begin
				got.path = path_t'(m_tuser[2:0]);
				got.dir = m_tdata[0];
				got.patience = m_tdata[16:1];
				got.fast_total = m_tdata[48:17];
				got.regular_total = m_tdata[80:49];
				got.bridge_total = m_tdata[112:81];
				got.reset_total = m_tdata[144:113];
				if (awaited_decisions.size() == 0) begin
					errors++;
					$display("%0t: result with none expected, path_taken expected none got %0d",
						$time, m_tuser);
				end else begin
					want = awaited_decisions.pop_front();
					want_f = flatten(want);
					got_f = flatten(got);
					for (i = 0; i < 7; i++)
						if (want_f[i] !== got_f[i]) begin
							errors++;
							$display("%0t: %s expected %0h got %0h", $time, field_name[i],
								want_f[i], got_f[i]);
						end
				end
			end
			if (s_tvalid && s_tready)
				awaited_decisions.push_back(select_path(s_tdata, s_tuser[0], s_tuser[1]));
			pending = awaited_decisions.size();
		end
	end

endmodule

FILE: verif/tb_top.sv
// Testbench top for the sequential key insert path selector: clock, reset,
// request and register stimulus, stall patterns and the verdict.
// Depends on skiq_pkg, the selector RTL and skiq_path_checker.
`timescale 1ns / 1ps
module tb_top;
	import skiq_pkg::*;

	localparam int unsigned WALK_ITEMS  = 204;
	localparam int unsigned QUIET_LIMIT = 3000;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;  // [31:0] key_value
	logic [IN_USER_W-1:0]  s_tuser  = '0;  // [0] four_byte_key, [1] store_ok
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// [0] direction_now, [16:1] patience_now, [48:17] fast_total,
	// [80:49] regular_total, [112:81] bridge_total, [144:113] reset_total
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [OUT_USER_W-1:0] m_tuser;  // [2:0] path_taken
	logic                  psel    = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite  = 1'b0;
	logic [PADDR_W-1:0]    paddr   = '0;
	logic [31:0]           pwdata  = '0;
	logic [31:0]           prdata;
	logic                  pready;

	int unsigned errors;
	int unsigned pending;
	int unsigned quiet_cycles = 0;
	int          send_calm = 0;
	int          stall_left = 0;
	int          flow_left = 0;

	// anchors, both fast-path flips, bridges both ways, preserves
	item_t opening_walk [16] = '{
		'{32'h0000_0000, 1'b0, 1'b0}, '{32'hFFFF_FFFF, 1'b0, 1'b1},
		'{32'hA5A5_A5A5, 1'b1, 1'b0}, '{32'h10FF_FF40, 1'b1, 1'b1},
		'{32'h10FF_FF80, 1'b1, 1'b1}, '{32'h1100_0000, 1'b1, 1'b0},
		'{32'h1100_0010, 1'b1, 1'b1}, '{32'h1100_0005, 1'b1, 1'b0},
		'{32'h1200_0000, 1'b1, 1'b1}, '{32'h10FF_FFFF, 1'b1, 1'b1},
		'{32'h10FF_FFFF, 1'b1, 1'b0}, '{32'h10FF_FF00, 1'b1, 1'b1},
		'{32'h10FF_FF01, 1'b1, 1'b0}, '{32'h10FE_0000, 1'b1, 1'b1},
		'{32'hFFFF_FFFF, 1'b1, 1'b0}, '{32'h0000_0000, 1'b1, 1'b1}
	};

	// patience runs out: hold at zero, expiry going forward and going backward
	item_t expiry_walk [8] = '{
		'{32'h10FF_FF02, 1'b1, 1'b1}, '{32'h10FF_FE00, 1'b1, 1'b0},
		'{32'h0000_0000, 1'b1, 1'b1}, '{32'h2000_0000, 1'b1, 1'b0},
		'{32'h2000_00F0, 1'b1, 1'b1}, '{32'h2000_0010, 1'b1, 1'b1},
		'{32'h3000_0000, 1'b1, 1'b0}, '{32'h1F00_0000, 1'b1, 1'b1}
	};

	logic [PAT_W-1:0] reload_plan [8] = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd65535, 16'd9,
		16'd40, 16'd300};

	sequential_key_insert_path_selector i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	skiq_path_checker i_path_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.pready   (pready),
		.errors   (errors),
		.pending  (pending)
	);

	always #5ns clk = ~clk;

	// result side: short and long stalls, with stretches of steady flow
	always @(posedge clk) begin
		int roll;
		if (stall_left > 0) begin
			stall_left--;
		end else if (flow_left > 0) begin
			flow_left--;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 15)
				stall_left = $urandom_range(1, 3);
			else if (roll < 18)
				stall_left = $urandom_range(15, 60);
			else if (roll < 22)
				flow_left = $urandom_range(50, 200);
		end
		m_tready <= (stall_left == 0);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAIL sequential_key_insert_path_selector");
				$finish;
			end
		end
	end

	// call at a rising edge; returns at the edge where the transaction is taken
	task automatic send_request(input item_t req);
		int gap;
		int roll;
		logic took;
		gap = 0;
		if (send_calm > 0) begin
			send_calm--;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 55)
				gap = 0;
			else if (roll < 85)
				gap = $urandom_range(1, 3);
			else if (roll < 95)
				gap = $urandom_range(4, 12);
			else if (roll < 98)
				gap = $urandom_range(30, 90);
			else
				send_calm = $urandom_range(40, 150);
		end
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= req.key;
		s_tuser <= {req.ok, req.four};
		do begin
			@(negedge clk);
			took = s_tready;
			@(posedge clk);
		end while (!took);
	endtask

	// stop sending and hold until every result is out
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({idx, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	initial begin
		item_t req;
		logic [KEY_W-1:0] cursor;
		int unsigned stride;
		int unsigned stride_max;
		int run_left;
		logic run_up;
		int roll;
		int walked;
		int ph;
		int i;
		cursor = $urandom;
		run_left = 0;
		run_up = 1'b1;
		stride_max = 8;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < 16; i++)
			send_request(opening_walk[i]);
		drain_results();
		write_reg(REG_RELOAD, 32'd1);
		write_reg(REG_START, 32'd0);
		for (i = 0; i < 8; i++)
			send_request(expiry_walk[i]);

		for (ph = 0; ph < 8; ph++) begin
			drain_results();
			write_reg(REG_RELOAD, (ph == 5) ? 32'($urandom_range(4, 30)) : 32'(reload_plan[ph]));
			write_reg(REG_START, 32'(ph % 2));
			walked = 0;
			while (walked < WALK_ITEMS) begin
				if (run_left == 0) begin
					roll = $urandom_range(0, 99);
					// jump, often next to a byte boundary so that runs cross it
					if (roll < 20) begin
						cursor = $urandom;
						if (roll < 8)
							cursor[23:8] = 16'hFFFF;
						else if (roll < 14)
							cursor[15:8] = 8'hFF;
					end
					run_left = $urandom_range(4, 40);
					run_up = $urandom_range(0, 1);
					roll = $urandom_range(0, 99);
					stride_max = (roll < 40) ? 8 : (roll < 75) ? 80 : (roll < 92) ? 300 : 70000;
				end
				run_left--;
				roll = $urandom_range(0, 99);
				if (roll < 6) begin
					req.key = $urandom;
					req.four = 1'b0;
				end else if (roll < 14) begin
					req.key = $urandom;
					req.four = 1'b1;
				end else begin
					stride = $urandom_range(0, stride_max);
					cursor = run_up ? cursor + stride : cursor - stride;
					req.key = cursor;
					req.four = 1'b1;
				end
				req.ok = $urandom_range(0, 1);
				send_request(req);
				walked++;
			end
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("PASS sequential_key_insert_path_selector");
		else
			$display("FAIL sequential_key_insert_path_selector");
		$finish;
	end

endmodule
